[sv/mneg_pkg.sv]
// Package: shared types, constants and register codes of the MIDI note echo generator.
`default_nettype none

package mneg_pkg;

  // Fixed-point and field widths
  localparam int FRAC_BITS   = 24;
  localparam int POW_W       = FRAC_BITS + 1;
  localparam int TICK_W      = 16;
  localparam int VEL_W       = 7;
  localparam int TRACK_W     = 8;
  localparam int REPEAT_W    = 5;
  localparam int DELAY_W     = 8;
  localparam int DECAY_W     = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int DEFAULT_MAX_REPEATS = 16;

  // Decay percent limit and factor constants: 2^24 = 167772 * 100 + 16
  localparam logic [DECAY_W-1:0] DECAY_FULL  = 7'd100;
  localparam logic [17:0]        FACTOR_INT  = 18'd167772;
  localparam logic [7:0]         FACTOR_FRAC = 8'd164;

  // Register reset values
  localparam logic [REPEAT_W-1:0] REPEAT_RST = '0;
  localparam logic [DELAY_W-1:0]  DELAY_RST  = '0;
  localparam logic [DECAY_W-1:0]  DECAY_RST  = 7'd100;
  localparam logic [TICK_W-1:0]   SEQLEN_RST = 16'hFFFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERCENT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQUENCE_LENGTH = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POWER,
    ST_SCAN,
    ST_FLUSH
  } mneg_state_t;

  typedef struct packed {
    logic load;
    logic pow_step;
    logic scan_step;
    logic flush_push;
  } mneg_cmd_t;

  typedef struct packed {
    logic idx_zero;
    logic at_count;
    logic cand_vld;
    logic pend_vld;
    logic out_free;
  } mneg_status_t;

endpackage

`default_nettype wire

[sv/mneg_if.sv]
// Interfaces: note input channel and echo output channel.
`default_nettype none

interface mneg_note_if
  import mneg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [TICK_W-1:0]  start_tick;
  logic [TICK_W-1:0]  end_tick;
  logic [VEL_W-1:0]   note_velocity;
  logic [TRACK_W-1:0] track_id;

  modport source (output valid, start_tick, end_tick, note_velocity, track_id,
                  input ready);
  modport sink (input valid, start_tick, end_tick, note_velocity, track_id,
                output ready);
endinterface

interface mneg_echo_if
  import mneg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [TICK_W-1:0]  echo_start;
  logic [TICK_W-1:0]  echo_end;
  logic [VEL_W-1:0]   echo_velocity;
  logic [TRACK_W-1:0] echo_track;
  logic               echo_last;

  modport source (output valid, echo_start, echo_end, echo_velocity, echo_track,
                  echo_last, input ready);
  modport sink (input valid, echo_start, echo_end, echo_velocity, echo_track,
                echo_last, output ready);
endinterface

`default_nettype wire

[sv/mneg_ctrl.sv]
// Controller: sequences power build-up, echo scan and final flush per note.
`default_nettype none

module mneg_ctrl
  import mneg_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire mneg_status_t status,
  output mneg_cmd_t         cmd
);

  mneg_state_t state;
  mneg_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_POWER;
        end
      end
      ST_POWER: begin
        if (status.at_count) begin
          state_next = ST_SCAN;
        end else begin
          cmd.pow_step = 1'b1;
        end
      end
      ST_SCAN: begin
        if (status.idx_zero) begin
          state_next = ST_FLUSH;
        end else if (!(status.cand_vld && status.pend_vld && !status.out_free)) begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!status.pend_vld) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.flush_push = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/mneg_datapath.sv]
// Datapath: config registers, power table, echo candidate, pending and output registers.
`default_nettype none

module mneg_datapath
  import mneg_pkg::*;
#(
  parameter int MAX_REPEATS = DEFAULT_MAX_REPEATS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire mneg_cmd_t             cmd,
  output mneg_status_t               status,
  input  wire logic [TICK_W-1:0]     in_start,
  input  wire logic [TICK_W-1:0]     in_end,
  input  wire logic [VEL_W-1:0]      in_vel,
  input  wire logic [TRACK_W-1:0]    in_track,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [TICK_W-1:0]          out_start,
  output logic [TICK_W-1:0]          out_end,
  output logic [VEL_W-1:0]           out_vel,
  output logic [TRACK_W-1:0]         out_track,
  output logic                       out_last
);

  localparam int IW   = $clog2(MAX_REPEATS + 1);
  localparam int OW   = DELAY_W + IW;
  localparam int SUMW = TICK_W + 1;

  // Configuration registers
  logic [REPEAT_W-1:0] repeat_count;
  logic [DELAY_W-1:0]  delay_ticks;
  logic [DECAY_W-1:0]  decay_percent;
  logic [TICK_W-1:0]   sequence_length;

  // Note registers
  logic [TICK_W-1:0]   note_start;
  logic [TICK_W-1:0]   note_end;
  logic [VEL_W-1:0]    note_vel;
  logic [TRACK_W-1:0]  note_track;
  logic [IW-1:0]       count;
  logic [IW-1:0]       idx;
  logic [OW-1:0]       offset;
  logic [POW_W-1:0]    factor;
  logic [POW_W-1:0]    pw_cur;
  logic [POW_W-1:0]    pw_mem [0:MAX_REPEATS];

  // Pending echo
  logic                pend_vld;
  logic [TICK_W-1:0]   pend_start;
  logic [TICK_W-1:0]   pend_end;
  logic [VEL_W-1:0]    pend_vel;

  // Combinational terms
  logic [IW-1:0]       count_clamp;
  logic [DECAY_W-1:0]  decay_clamp;
  logic [POW_W-1:0]    factor_calc;
  logic [2*POW_W-1:0]  pow_prod;
  logic [POW_W-1:0]    pow_next;
  logic [31:0]         vel_prod;
  logic [VEL_W-1:0]    cand_vel;
  logic [SUMW-1:0]     end_sum;
  logic [SUMW-1:0]     start_sum;
  logic [TICK_W-1:0]   cand_start;
  logic                cand_vld;
  logic                out_free;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_count    <= REPEAT_RST;
      delay_ticks     <= DELAY_RST;
      decay_percent   <= DECAY_RST;
      sequence_length <= SEQLEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPEAT_COUNT:    repeat_count    <= cfg_data[REPEAT_W-1:0];
        CFG_DELAY_TICKS:     delay_ticks     <= cfg_data[DELAY_W-1:0];
        CFG_DECAY_PERCENT:   decay_percent   <= cfg_data[DECAY_W-1:0];
        CFG_SEQUENCE_LENGTH: sequence_length <= cfg_data[TICK_W-1:0];
      endcase
    end
  end

  // Clamp count and decay; decay factor = floor(d * 2^24 / 100)
  always_comb begin
    if (32'(repeat_count) > 32'(MAX_REPEATS)) begin
      count_clamp = IW'(MAX_REPEATS);
    end else begin
      count_clamp = IW'(32'(repeat_count));
    end
    decay_clamp = (decay_percent > DECAY_FULL) ? DECAY_FULL : decay_percent;
    factor_calc = POW_W'(decay_clamp) * POW_W'(FACTOR_INT) +
                  POW_W'((15'(decay_clamp) * 15'(FACTOR_FRAC)) >> 10);
  end

  // Power step, truncated
  assign pow_prod = pw_cur * factor;
  assign pow_next = pow_prod[FRAC_BITS +: POW_W];

  // Echo candidate at current index
  always_comb begin
    vel_prod   = 32'(note_vel) * 32'(pw_cur);
    cand_vel   = vel_prod[FRAC_BITS +: VEL_W];
    end_sum    = SUMW'(note_end) + SUMW'(offset);
    start_sum  = SUMW'(note_start) + SUMW'(offset);
    cand_start = start_sum[TICK_W] ? '1 : start_sum[TICK_W-1:0];
    cand_vld   = (end_sum <= SUMW'(sequence_length)) && (cand_vel != '0);
  end

  assign out_free = !out_valid || out_ready;

  // Load note, build powers, scan down
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      note_start <= in_start;
      note_end   <= in_end;
      note_vel   <= in_vel;
      note_track <= in_track;
      count      <= count_clamp;
      factor     <= factor_calc;
      idx        <= '0;
      offset     <= '0;
      pw_cur     <= POW_W'(1) << FRAC_BITS;
      pw_mem[0]  <= POW_W'(1) << FRAC_BITS;
    end else if (cmd.pow_step) begin
      idx              <= idx + IW'(1);
      offset           <= offset + OW'(delay_ticks);
      pw_cur           <= pow_next;
      pw_mem[idx + IW'(1)] <= pow_next;
    end else if (cmd.scan_step) begin
      idx    <= idx - IW'(1);
      offset <= offset - OW'(delay_ticks);
      pw_cur <= pw_mem[idx - IW'(1)];
    end
  end

  // Hold pending echo
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
    end else if (cmd.flush_push) begin
      pend_vld <= 1'b0;
    end else if (cmd.scan_step && cand_vld) begin
      pend_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && cand_vld) begin
      pend_start <= cand_start;
      pend_end   <= end_sum[TICK_W-1:0];
      pend_vel   <= cand_vel;
    end
  end

  // Output register: push pending echo when a newer one replaces it, or at flush
  logic push;
  assign push = cmd.flush_push || (cmd.scan_step && cand_vld && pend_vld);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_start <= pend_start;
      out_end   <= pend_end;
      out_vel   <= pend_vel;
      out_track <= note_track;
      out_last  <= cmd.flush_push;
    end
  end

  // Status to controller
  always_comb begin
    status.idx_zero = (idx == '0);
    status.at_count = (idx == count);
    status.cand_vld = cand_vld;
    status.pend_vld = pend_vld;
    status.out_free = out_free;
  end

endmodule

`default_nettype wire

[sv/midi_note_echo_generator.sv]
// Top level: MIDI note echo generator, controller plus datapath.
//
//  channel   | dir | transfer when        | payload
//  note_in   | in  | valid & ready        | start_tick, end_tick, note_velocity, track_id
//  echo_out  | out | valid & ready        | echo_start, echo_end, echo_velocity,
//            |     |                      |   echo_track, echo_last
//  cfg       | in  | cfg_we               | cfg_index, cfg_data
//
// A note with N echoes (N = repeat count clamped to MAX_REPEATS) passes, from its
// transfer to the next ready, through one load, N power steps plus one turn step,
// N scan steps plus one step at index zero, and one flush.
// A full output register holds the scan when a second echo waits, and holds the flush.
// Reset (rst, synchronous) returns the sequencer to idle and the registers to
// their reset values; note_in is taken only when idle.
`default_nettype none

module midi_note_echo_generator
  import mneg_pkg::*;
#(
  parameter int MAX_REPEATS = DEFAULT_MAX_REPEATS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  mneg_note_if.sink                  note_in,
  mneg_echo_if.source                echo_out,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  mneg_cmd_t    cmd;
  mneg_status_t status;
  logic         in_ready;

  assign note_in.ready = in_ready;

  mneg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (note_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mneg_datapath #(
    .MAX_REPEATS (MAX_REPEATS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .in_start  (note_in.start_tick),
    .in_end    (note_in.end_tick),
    .in_vel    (note_in.note_velocity),
    .in_track  (note_in.track_id),
    .out_valid (echo_out.valid),
    .out_ready (echo_out.ready),
    .out_start (echo_out.echo_start),
    .out_end   (echo_out.echo_end),
    .out_vel   (echo_out.echo_velocity),
    .out_track (echo_out.echo_track),
    .out_last  (echo_out.echo_last)
  );

endmodule

`default_nettype wire

[verif/tb.sv]
// Testbench for the MIDI note echo generator: random notes, settings and stalls, checked echoes.
`default_nettype none

module tb;
  import mneg_pkg::*;

  localparam int ECHO_MAX      = DEFAULT_MAX_REPEATS;
  localparam int SETTLE_CYCLES = 2 * ECHO_MAX + 30;
  localparam int RANDOM_NOTES  = 500;

  typedef struct packed {
    logic [TICK_W-1:0]  start_tick;
    logic [TICK_W-1:0]  end_tick;
    logic [VEL_W-1:0]   note_velocity;
    logic [TRACK_W-1:0] track_id;
  } note_t;

  typedef struct packed {
    logic [TICK_W-1:0]  echo_start;
    logic [TICK_W-1:0]  echo_end;
    logic [VEL_W-1:0]   echo_velocity;
    logic [TRACK_W-1:0] echo_track;
    logic               echo_last;
  } echo_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_REPEAT_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic  note_vld  = 1'b0;
  note_t note_item = '0;
  logic  echo_rdy  = 1'b0;

  // Register copies kept by the predictor
  logic [REPEAT_W-1:0] rpt_cfg = REPEAT_RST;
  logic [DELAY_W-1:0]  dly_cfg = DELAY_RST;
  logic [DECAY_W-1:0]  dcy_cfg = DECAY_RST;
  logic [TICK_W-1:0]   seq_cfg = SEQLEN_RST;

  note_t notes_to_send [$];
  echo_t echoes_due [$];

  int notes_accepted = 0;
  int notes_drv_seen = 0;
  int echoes_checked = 0;
  int fail_count     = 0;
  int settings_used  = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int pat_mode       = 0;
  int pat_left       = 0;
  int hold_left      = 0;

  mneg_note_if note_if ();
  mneg_echo_if echo_if ();

  assign note_if.valid         = note_vld;
  assign note_if.start_tick    = note_item.start_tick;
  assign note_if.end_tick      = note_item.end_tick;
  assign note_if.note_velocity = note_item.note_velocity;
  assign note_if.track_id      = note_item.track_id;
  assign echo_if.ready         = echo_rdy;

  midi_note_echo_generator uut (
    .clk       (clk),
    .rst       (rst),
    .note_in   (note_if),
    .echo_out  (echo_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Expand one note into its echoes, highest index first; flag the final one
  function automatic void predict_echoes(input note_t nt);
    int          reps;
    int          k;
    logic [63:0] factor;
    logic [63:0] offset;
    logic [63:0] pos_start;
    logic [63:0] pos_end;
    logic [63:0] level;
    logic [63:0] pow_tab [0:ECHO_MAX];
    echo_t       held;
    echo_t       cur;
    bit          have;
    reps = (rpt_cfg > ECHO_MAX) ? ECHO_MAX : int'(rpt_cfg);
    factor = (dcy_cfg > DECAY_FULL) ? 64'(DECAY_FULL) : 64'(dcy_cfg);
    factor = (factor << FRAC_BITS) / 64'(DECAY_FULL);
    pow_tab[0] = 64'd1 << FRAC_BITS;
    for (k = 1; k <= reps; k++) begin
      pow_tab[k] = (pow_tab[k-1] * factor) >> FRAC_BITS;
    end
    have = 1'b0;
    held = '0;
    for (k = reps; k >= 1; k--) begin
      offset  = 64'(k) * 64'(dly_cfg);
      pos_end = 64'(nt.end_tick) + offset;
      if (pos_end > 64'(seq_cfg)) continue;
      level = (64'(nt.note_velocity) * pow_tab[k]) >> FRAC_BITS;
      if (level == 0) continue;
      pos_start = 64'(nt.start_tick) + offset;
      if (pos_start > 64'hFFFF) pos_start = 64'hFFFF;
      cur.echo_start    = pos_start[TICK_W-1:0];
      cur.echo_end      = pos_end[TICK_W-1:0];
      cur.echo_velocity = level[VEL_W-1:0];
      cur.echo_track    = nt.track_id;
      cur.echo_last     = 1'b0;
      if (have) echoes_due = {echoes_due, held};
      held = cur;
      have = 1'b1;
    end
    if (have) begin
      held.echo_last = 1'b1;
      echoes_due = {echoes_due, held};
    end
  endfunction

  // Note driver: bursts with random gaps, noise payload while idle
  always @(negedge clk) begin : drive_notes
    note_t nxt;
    logic  go;
    go  = note_vld;
    nxt = note_item;
    if (note_vld && notes_accepted != notes_drv_seen) begin
      notes_drv_seen = notes_accepted;
      go = 1'b0;
    end
    if (!go && !rst) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (notes_to_send.size() != 0) begin
        nxt = notes_to_send.pop_front();
        go  = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 10);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
    end
    if (!go) begin
      nxt.start_tick    = TICK_W'($urandom);
      nxt.end_tick      = TICK_W'($urandom);
      nxt.note_velocity = VEL_W'($urandom);
      nxt.track_id      = TRACK_W'($urandom);
    end
    note_vld  <= go;
    note_item <= nxt;
  end

  // Echo receiver: switch between free flow, random stalls and long stalls
  always @(negedge clk) begin : drive_ready
    logic nxt_rdy;
    nxt_rdy = echo_rdy;
    if (pat_left == 0) begin
      pat_mode = $urandom_range(0, 2);
      pat_left = $urandom_range(40, 200);
    end else begin
      pat_left--;
    end
    case (pat_mode)
      0: begin
        nxt_rdy = 1'b1;
      end
      1: begin
        nxt_rdy = 1'($urandom_range(0, 1));
      end
      default: begin
        if (hold_left == 0) begin
          nxt_rdy   = ~echo_rdy;
          hold_left = nxt_rdy ? $urandom_range(1, 4) : $urandom_range(1, 12);
        end else begin
          hold_left--;
        end
      end
    endcase
    echo_rdy <= nxt_rdy;
  end

  // Monitor: predict on note transfers, check each echo transfer
  always @(posedge clk) begin : watch_ports
    note_t nt;
    echo_t got;
    echo_t want;
    if (!rst) begin
      if (note_if.valid && note_if.ready) begin
        nt.start_tick    = note_if.start_tick;
        nt.end_tick      = note_if.end_tick;
        nt.note_velocity = note_if.note_velocity;
        nt.track_id      = note_if.track_id;
        notes_accepted++;
        predict_echoes(nt);
      end
      if (echo_if.valid && echo_if.ready) begin
        got.echo_start    = echo_if.echo_start;
        got.echo_end      = echo_if.echo_end;
        got.echo_velocity = echo_if.echo_velocity;
        got.echo_track    = echo_if.echo_track;
        got.echo_last     = echo_if.echo_last;
        echoes_checked++;
        if (echoes_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected echo: start=%0d end=%0d vel=%0d track=%0d last=%0b",
                     got.echo_start, got.echo_end, got.echo_velocity, got.echo_track,
                     got.echo_last);
        end else begin
          want = echoes_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("echo mismatch #%0d (note %0d):", echoes_checked, notes_accepted);
              $display("  expected start=%0d end=%0d vel=%0d track=%0d last=%0b",
                       want.echo_start, want.echo_end, want.echo_velocity,
                       want.echo_track, want.echo_last);
              $display("  actual   start=%0d end=%0d vel=%0d track=%0d last=%0b",
                       got.echo_start, got.echo_end, got.echo_velocity,
                       got.echo_track, got.echo_last);
            end
          end
        end
      end
    end
  end

  // Write one register and track it, keeping only the register's own bits
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      CFG_REPEAT_COUNT:    rpt_cfg = value[REPEAT_W-1:0];
      CFG_DELAY_TICKS:     dly_cfg = value[DELAY_W-1:0];
      CFG_DECAY_PERCENT:   dcy_cfg = value[DECAY_W-1:0];
      CFG_SEQUENCE_LENGTH: seq_cfg = value[TICK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Load all four registers, sometimes with junk above the count, delay and decay widths
  task automatic set_echo_config(input int reps, input int spacing, input int decay,
                                 input int seq_len);
    logic [CFG_DATA_W-1:0] word;
    word = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom) : '0;
    word[REPEAT_W-1:0] = REPEAT_W'(reps);
    write_reg(CFG_REPEAT_COUNT, word);
    word = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom) : '0;
    word[DELAY_W-1:0] = DELAY_W'(spacing);
    write_reg(CFG_DELAY_TICKS, word);
    word = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom) : '0;
    word[DECAY_W-1:0] = DECAY_W'(decay);
    write_reg(CFG_DECAY_PERCENT, word);
    write_reg(CFG_SEQUENCE_LENGTH, CFG_DATA_W'(seq_len));
    settings_used++;
  endtask

  task automatic queue_note(input int st, input int en, input int vel, input int trk);
    note_t nt;
    nt.start_tick    = TICK_W'(st);
    nt.end_tick      = TICK_W'(en);
    nt.note_velocity = VEL_W'(vel);
    nt.track_id      = TRACK_W'(trk);
    notes_to_send = {notes_to_send, nt};
  endtask

  // Wait until all notes are out, all echoes back, and the block has gone idle
  task automatic drain_block();
    while (notes_to_send.size() != 0 || note_vld || echoes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly notes that fit the sequence, some pinned to its edge, some pure noise
  task automatic queue_random_note();
    note_t nt;
    int    reps;
    int    span;
    reps = (rpt_cfg > ECHO_MAX) ? ECHO_MAX : int'(rpt_cfg);
    span = reps * int'(dly_cfg);
    nt.start_tick    = TICK_W'($urandom);
    nt.end_tick      = TICK_W'($urandom);
    nt.note_velocity = VEL_W'($urandom);
    nt.track_id      = TRACK_W'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      if (span <= int'(seq_cfg)) begin
        if ($urandom_range(0, 3) == 0)
          nt.end_tick = TICK_W'(int'(seq_cfg) -
                                int'($urandom_range(0, reps)) * int'(dly_cfg));
        else
          nt.end_tick = TICK_W'($urandom_range(0, int'(seq_cfg) - span));
      end
      if ($urandom_range(0, 3) == 0)
        nt.start_tick = TICK_W'(65535 - $urandom_range(0, 4095));
      if ($urandom_range(0, 7) != 0) nt.note_velocity = VEL_W'($urandom_range(1, 127));
    end
    notes_to_send = {notes_to_send, nt};
  endtask

  task automatic pick_random_config();
    int reps;
    int spacing;
    int decay;
    int seq_len;
    case ($urandom_range(0, 7))
      0:       reps = $urandom_range(17, 31);
      1:       reps = 0;
      default: reps = $urandom_range(1, ECHO_MAX);
    endcase
    case ($urandom_range(0, 7))
      0:       spacing = 0;
      1:       spacing = $urandom_range(192, 255);
      default: spacing = $urandom_range(1, 64);
    endcase
    case ($urandom_range(0, 7))
      0:       decay = $urandom_range(101, 127);
      1:       decay = $urandom_range(0, 10);
      default: decay = $urandom_range(30, 100);
    endcase
    case ($urandom_range(0, 3))
      0:       seq_len = 65535;
      1:       seq_len = $urandom_range(0, 65535);
      default: seq_len = $urandom_range(20000, 65535);
    endcase
    set_echo_config(reps, spacing, decay, seq_len);
  endtask

  initial begin : stimulus
    int random_sent;
    int phase_len;
    random_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: no echoes at all
    queue_note(100, 200, 127, 1);
    queue_note(65535, 65535, 127, 255);
    drain_block();

    // Zero delay, full decay: all sixteen echoes stack on the note
    set_echo_config(16, 0, 100, 65535);
    queue_note(0, 0, 127, 0);
    queue_note(65535, 65535, 127, 255);
    queue_note(0, 65535, 0, 170);
    queue_note(1234, 1300, 1, 85);
    drain_block();

    // Repeat count and decay above their limits, start saturation, end past length
    set_echo_config(31, 192, 127, 4000);
    queue_note(65535, 0, 100, 3);
    queue_note(65000, 1500, 64, 7);
    queue_note(3000, 3999, 90, 9);
    queue_note(4000, 4000, 50, 1);
    drain_block();

    // No decay kept: every echo drops out
    set_echo_config(5, 255, 0, 65535);
    queue_note(60000, 62000, 127, 200);
    queue_note(0, 0, 127, 2);
    drain_block();

    // Halving decay: late echoes fall to zero velocity
    set_echo_config(8, 255, 50, 65535);
    queue_note(60000, 62000, 127, 200);
    queue_note(0, 0, 3, 2);
    drain_block();

    // Zero sequence length
    set_echo_config(3, 0, 37, 0);
    queue_note(0, 0, 127, 4);
    queue_note(9, 1, 127, 4);
    drain_block();

    set_echo_config(0, 0, 100, 65535);
    queue_note(500, 600, 127, 12);
    drain_block();

    // Random settings, each with a run of random notes
    while (random_sent < RANDOM_NOTES) begin
      pick_random_config();
      phase_len = $urandom_range(30, 70);
      repeat (phase_len) queue_random_note();
      random_sent += phase_len;
      drain_block();
    end

    $display("Sent %0d notes over %0d register settings with random bursts and stalls;",
             notes_accepted, settings_used);
    $display("checked %0d echoes, %0d failures.", echoes_checked, fail_count);
    if (fail_count == 0)
      $display("** midi_note_echo_generator: PASSED **");
    else
      $display("** midi_note_echo_generator: FAILED **");
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("Timeout with %0d echoes still due", echoes_due.size());
    $display("** midi_note_echo_generator: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
